// ===== rtl/core/dfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfd_pkg
// Types and constants shared by the deauthentication flood detector modules.
// ----------------------------------------------------------------------------
package dfd_pkg;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned THRESH_W = 8;
    localparam int unsigned RCNT_W   = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Saturation value of the reported recent count.
    localparam int unsigned RCNT_MAX = 63;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 2'd2;

    // Register reset values.
    localparam logic                DETECT_ENABLE_RST   = 1'b1;
    localparam logic [TICK_W-1:0]   WINDOW_TICKS_RST    = 32'd5000;
    localparam logic [THRESH_W-1:0] COUNT_THRESHOLD_RST = 8'd10;

    typedef struct packed {
        logic [ADDR_W-1:0] ap_address;
        logic [TICK_W-1:0] now_tick;
    } in_word_t;

    typedef struct packed {
        logic              alert;
        logic [RCNT_W-1:0] recent_count;
        logic [ADDR_W-1:0] alert_address;
        logic [TICK_W-1:0] alerts_total;
    } out_word_t;

    // Broadcast from the controller to every record cell.
    typedef struct packed {
        logic              clear;
        logic [TICK_W-1:0] wr_stamp;
        logic [TICK_W-1:0] now_tick;
        logic [TICK_W-1:0] window_ticks;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/dfd_cell.sv =====
// ----------------------------------------------------------------------------
// dfd_cell
// One record of the ring: a stored stamp with its valid mark, and one stage
// of the counting chain that adds this record's hit to the passing count.
// ----------------------------------------------------------------------------
module dfd_cell #(
    parameter int unsigned CNT_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  dfd_pkg::cell_ctrl_t ctrl,
    input  logic                tok_in_valid,
    input  logic [CNT_W-1:0]    tok_in_count,
    output logic                tok_out_valid,
    output logic [CNT_W-1:0]    tok_out_count,
    output logic                rec_valid
);

    logic [dfd_pkg::TICK_W-1:0] stamp_reg;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       tok_valid_reg;
    logic [CNT_W-1:0]           tok_count_reg;
    logic [dfd_pkg::TICK_W-1:0] age;
    logic                       hit;

    // Wrapped age; the record counts when it is strictly younger than the window.
    assign age = ctrl.now_tick - stamp_reg;
    assign hit = valid_reg && (age < ctrl.window_ticks);

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next = 1'b1;
        end else if (ctrl.clear) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stamp_reg <= ctrl.wr_stamp;
        end
        if (tok_in_valid) begin
            tok_count_reg <= tok_in_count + CNT_W'(hit);
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_count = tok_count_reg;
    assign rec_valid     = valid_reg;

endmodule

// ===== rtl/core/deauth_flood_detector_top.sv =====
// ----------------------------------------------------------------------------
// deauth_flood_detector_top
// Sliding-window deauthentication flood detector. Each input word is one
// observed deauthentication frame (access point address and millisecond
// tick); each output word reports the recent-frame count and the alert.
// The frame's tick is stored in a ring of RECORD_DEPTH record cells at the
// write pointer, whether or not detection is enabled. With detection enabled,
// a count word walks the chain of cells, one cell per clock, and each cell
// adds one when its record is valid and its wrapped age is below the window.
// When the total reaches the threshold an alert is raised, the alert counter
// increments and all records are invalidated; the write pointer is kept.
// The next frame is accepted once the sequencer is back in IDLE; with
// detection enabled it waits in WALK until the count word leaves the last
// cell. The result sits in an output register, so a new frame is accepted
// while the previous result still waits for m_ready. Configuration is
// written through cfg_wr_en, cfg_index and cfg_wdata while the block is
// idle; the user must ensure this, as the block does not enforce it.
// ----------------------------------------------------------------------------
module deauth_flood_detector_top #(
    parameter int unsigned RECORD_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [dfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Frame input channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dfd_pkg::in_word_t                  s_data,
    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output dfd_pkg::out_word_t                 m_data
);

    localparam int unsigned PW = $clog2(RECORD_DEPTH);
    localparam int unsigned CW = $clog2(RECORD_DEPTH + 1);

    // Configuration registers.
    logic                               detect_enable_reg;
    logic [dfd_pkg::TICK_W-1:0]         window_ticks_reg;
    logic [dfd_pkg::THRESH_W-1:0]       count_threshold_reg;

    // Control state.
    dfd_pkg::state_t                    state_reg;
    dfd_pkg::state_t                    state_next;
    logic [PW-1:0]                      ptr_reg;
    logic [PW-1:0]                      ptr_next;
    logic                               head_reg;
    logic                               en_reg;
    logic [dfd_pkg::TICK_W-1:0]         alert_counter_reg;
    logic                               m_valid_reg;

    // Per-frame payload.
    logic [dfd_pkg::ADDR_W-1:0]         addr_reg;
    logic [dfd_pkg::TICK_W-1:0]         now_reg;
    logic [CW-1:0]                      count_reg;
    dfd_pkg::out_word_t                 m_data_reg;
    dfd_pkg::out_word_t                 out_next;

    logic                               accept;
    logic                               load_out;
    logic [CW-1:0]                      count_used;
    logic                               alert_next;

    // Counting chain.
    logic [RECORD_DEPTH:0]              tok_valid;
    logic [CW-1:0]                      tok_count [RECORD_DEPTH+1];
    logic [RECORD_DEPTH-1:0]            rec_valid;
    dfd_pkg::cell_ctrl_t                cell_ctrl;

    assign accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Configuration registers. Writes to an unused index are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detect_enable_reg   <= dfd_pkg::DETECT_ENABLE_RST;
            window_ticks_reg    <= dfd_pkg::WINDOW_TICKS_RST;
            count_threshold_reg <= dfd_pkg::COUNT_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dfd_pkg::CFG_DETECT_ENABLE: begin
                    detect_enable_reg <= cfg_wdata[0];
                end
                dfd_pkg::CFG_WINDOW_TICKS: begin
                    window_ticks_reg <= cfg_wdata[dfd_pkg::TICK_W-1:0];
                end
                dfd_pkg::CFG_COUNT_THRESHOLD: begin
                    count_threshold_reg <= cfg_wdata[dfd_pkg::THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. IDLE takes a frame and writes its record; WALK waits for
    // the count word to leave the last cell; FINISH hands the result to
    // the output register as soon as that register is free.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dfd_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = detect_enable_reg ? dfd_pkg::ST_WALK : dfd_pkg::ST_FINISH;
                end
            end
            dfd_pkg::ST_WALK: begin
                if (tok_valid[RECORD_DEPTH]) begin
                    state_next = dfd_pkg::ST_FINISH;
                end
            end
            dfd_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = dfd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            dfd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            dfd_pkg::ST_WALK: begin
            end
            dfd_pkg::ST_FINISH: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // The pointer wraps at the depth, which need not be a power of two.
    always_comb begin
        ptr_next = ptr_reg;
        if (accept) begin
            if (ptr_reg == PW'(RECORD_DEPTH - 1)) begin
                ptr_next = '0;
            end else begin
                ptr_next = ptr_reg + PW'(1);
            end
        end
    end

    // Result of the finished frame. With detection disabled the count is zero.
    always_comb begin
        count_used = en_reg ? count_reg : '0;
        alert_next = en_reg &&
                     (32'(count_used) >= 32'(count_threshold_reg));
        out_next.alert         = alert_next;
        out_next.recent_count  = (32'(count_used) > 32'(dfd_pkg::RCNT_MAX)) ?
                                 dfd_pkg::RCNT_W'(dfd_pkg::RCNT_MAX) :
                                 dfd_pkg::RCNT_W'(count_used);
        out_next.alert_address = addr_reg;
        out_next.alerts_total  = alert_next ? alert_counter_reg + 32'd1 :
                                 alert_counter_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= dfd_pkg::ST_IDLE;
            ptr_reg           <= '0;
            head_reg          <= 1'b0;
            en_reg            <= 1'b0;
            alert_counter_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            // The count word enters the chain in the cycle after the record write,
            // so the cell written for this frame already holds the new stamp.
            head_reg  <= accept && detect_enable_reg;
            if (accept) begin
                en_reg <= detect_enable_reg;
            end
            if (load_out) begin
                alert_counter_reg <= out_next.alerts_total;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_data.ap_address;
            now_reg  <= s_data.now_tick;
        end
        if (tok_valid[RECORD_DEPTH]) begin
            count_reg <= tok_count[RECORD_DEPTH];
        end
        if (load_out) begin
            m_data_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Chain of record cells.
    // ------------------------------------------------------------------
    assign cell_ctrl.clear        = load_out && alert_next;
    assign cell_ctrl.wr_stamp     = s_data.now_tick;
    assign cell_ctrl.now_tick     = now_reg;
    assign cell_ctrl.window_ticks = window_ticks_reg;

    assign tok_valid[0] = head_reg;
    assign tok_count[0] = '0;

    for (genvar i = 0; i < RECORD_DEPTH; i++) begin : g_cell
        dfd_cell #(
            .CNT_W (CW)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .wr_en         (accept && (ptr_reg == PW'(i))),
            .ctrl          (cell_ctrl),
            .tok_in_valid  (tok_valid[i]),
            .tok_in_count  (tok_count[i]),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out_count (tok_count[i+1]),
            .rec_valid     (rec_valid[i])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // At most one count word travels the chain.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid))
        else $error("more than one count word in the cell chain");

    // While walking, the count word is somewhere in the chain.
    a_walk_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dfd_pkg::ST_WALK) |-> ($countones(tok_valid) == 1))
        else $error("walk state without a count word in the chain");

    // An alert leaves every record invalid.
    a_alert_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && alert_next) |=> (rec_valid == '0))
        else $error("records still valid after an alert");

    // The alert counter moves only with an alert result.
    a_counter_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (alert_counter_reg != $past(alert_counter_reg)) |->
        (m_valid_reg && m_data_reg.alert &&
         (m_data_reg.alerts_total == alert_counter_reg)))
        else $error("alert counter changed without an alert result");
`endif

endmodule

// ===== tb/sv/tb_deauth_flood_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deauth_flood_detector_top
// Self-checking bench for the deauthentication flood detector. Frames are
// driven through the valid/ready input channel, with bursts and gaps. A
// behavioral copy of the record ring predicts every result word. Each word
// taken from the result channel, which stalls on its own pattern, is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_deauth_flood_detector_top;

    localparam int unsigned RECORD_DEPTH = 32;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [dfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // Receiver behavior, chosen anew at random when the current mode runs out.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_LIGHT,
        RX_HEAVY,
        RX_LONG_HOLD
    } rx_mode_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [dfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    dfd_pkg::in_word_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    dfd_pkg::out_word_t             m_data;

    deauth_flood_detector_top #(
        .RECORD_DEPTH(RECORD_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Behavioral copy of the detector: the ring of stamps with their valid
    // marks, the write pointer, the alert counter and the three registers.
    // ------------------------------------------------------------------------
    logic [dfd_pkg::TICK_W-1:0]   rec_stamp [RECORD_DEPTH];
    logic [RECORD_DEPTH-1:0]      rec_valid     = '0;
    int unsigned                  rec_wptr      = 0;
    logic [dfd_pkg::TICK_W-1:0]   flood_alerts  = '0;
    logic                         cfg_enable    = dfd_pkg::DETECT_ENABLE_RST;
    logic [dfd_pkg::TICK_W-1:0]   cfg_window    = dfd_pkg::WINDOW_TICKS_RST;
    logic [dfd_pkg::THRESH_W-1:0] cfg_threshold = dfd_pkg::COUNT_THRESHOLD_RST;

    // Predicted result words, oldest first.
    dfd_pkg::out_word_t expected_results [$];
    int unsigned error_count = 0;

    // Sender pacing: words left in the current burst.
    int unsigned burst_left = 0;

    // Receiver pacing state.
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int unsigned rx_mode_left = 0;
    int unsigned rx_hold_left = 0;

    initial begin
        for (int i = 0; i < RECORD_DEPTH; i++) begin
            rec_stamp[i] = '0;
        end
    end

    // Stores the frame's tick, then counts the recent valid records when the
    // check is enabled. The record just written is part of the count. An
    // alert clears every valid mark but leaves the write pointer alone.
    function automatic dfd_pkg::out_word_t detect_flood(input dfd_pkg::in_word_t frame);
        dfd_pkg::out_word_t         res;
        int unsigned                hits;
        logic [dfd_pkg::TICK_W-1:0] age;
        logic                       raised;
        hits   = 0;
        raised = 1'b0;
        rec_stamp[rec_wptr] = frame.now_tick;
        rec_valid[rec_wptr] = 1'b1;
        rec_wptr = (rec_wptr + 1) % RECORD_DEPTH;
        if (cfg_enable) begin
            for (int i = 0; i < RECORD_DEPTH; i++) begin
                // The age wraps modulo 2^32, so a stamp ahead of now looks old.
                age = frame.now_tick - rec_stamp[i];
                if (rec_valid[i] && age < cfg_window) begin
                    hits++;
                end
            end
            if (hits >= cfg_threshold) begin
                raised       = 1'b1;
                flood_alerts = flood_alerts + 1'b1;
                rec_valid    = '0;
            end
        end
        res.alert         = raised;
        res.recent_count  = dfd_pkg::RCNT_W'((hits > dfd_pkg::RCNT_MAX) ?
                                             dfd_pkg::RCNT_MAX : hits);
        res.alert_address = frame.ap_address;
        res.alerts_total  = flood_alerts;
        return res;
    endfunction

    function automatic logic [dfd_pkg::ADDR_W-1:0] rand_address();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[dfd_pkg::ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge after the
    // word was taken. Within a burst, valid stays high and the next call puts
    // new data on the bus at that same falling edge. At the end of a burst,
    // valid drops for a random gap. Long gaps range from shorter to longer than
    // a full walk of the ring, so idle time lands on every phase of its work.
    // ------------------------------------------------------------------------
    task automatic send_frame(input dfd_pkg::in_word_t frame);
        int unsigned gap;
        s_data  = frame;
        s_valid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_results.push_back(detect_flood(frame));
        @(negedge aclk);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            s_valid = 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 45)
                                               : $urandom_range(0, 6);
            repeat (gap) @(negedge aclk);
            // Some bursts are long, so there are stretches with no gaps.
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Parks the sender and waits until every predicted word has come out.
    task automatic drain_results();
        s_valid = 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Writes one register while the block is idle and mirrors it in the
    // predictor. A write to an index with no register changes nothing.
    task automatic write_register(input logic [dfd_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [dfd_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            dfd_pkg::CFG_DETECT_ENABLE:   cfg_enable    = data[0];
            dfd_pkg::CFG_WINDOW_TICKS:    cfg_window    = data[dfd_pkg::TICK_W-1:0];
            dfd_pkg::CFG_COUNT_THRESHOLD: cfg_threshold = data[dfd_pkg::THRESH_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver. m_ready changes at the falling edge. The mode decides between
    // always ready, light or heavy random stalls, and long holds.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 150);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_ALWAYS: m_ready = 1'b1;
            RX_LIGHT:  m_ready = ($urandom_range(0, 3) != 0);
            RX_HEAVY:  m_ready = ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold_left != 0) begin
                    rx_hold_left--;
                    m_ready = 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_hold_left = $urandom_range(5, 40);
                    m_ready      = 1'b0;
                end else begin
                    m_ready = 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Checker. Every word taken from the result channel is compared with the
    // oldest prediction. A word that arrives with nothing predicted is an
    // error of its own.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dfd_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with none expected: %h", m_data);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.alert !== want.alert) begin
                    $error("alert: expected %0d, got %0d", want.alert, m_data.alert);
                    error_count++;
                end
                if (m_data.recent_count !== want.recent_count) begin
                    $error("recent_count: expected %0d, got %0d",
                           want.recent_count, m_data.recent_count);
                    error_count++;
                end
                if (m_data.alert_address !== want.alert_address) begin
                    $error("alert_address: expected %h, got %h",
                           want.alert_address, m_data.alert_address);
                    error_count++;
                end
                if (m_data.alerts_total !== want.alerts_total) begin
                    $error("alerts_total: expected %0d, got %0d",
                           want.alerts_total, m_data.alerts_total);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // The reset registers (window 5000, threshold 10): ten frames 400 ticks
    // apart fill the window, and the tenth one raises the alert. The first
    // and last addresses are all zeros and all ones.
    task automatic test_default_threshold();
        dfd_pkg::in_word_t frame;
        for (int i = 0; i < 10; i++) begin
            if (i == 0) begin
                frame.ap_address = '0;
            end else if (i == 9) begin
                frame.ap_address = '1;
            end else begin
                frame.ap_address = rand_address();
            end
            frame.now_tick = 32'd1000 + i * 400;
            send_frame(frame);
        end
    endtask

    // With detection off, frames are still stored but report nothing. Once
    // it is back on, those stored records count toward the next frame.
    task automatic test_detect_disabled();
        dfd_pkg::in_word_t frame;
        write_register(dfd_pkg::CFG_DETECT_ENABLE, 32'd0);
        for (int i = 0; i < 3; i++) begin
            frame.ap_address = rand_address();
            frame.now_tick   = 32'd6000 + i * 10;
            send_frame(frame);
        end
        write_register(dfd_pkg::CFG_DETECT_ENABLE, 32'd1);
        write_register(dfd_pkg::CFG_COUNT_THRESHOLD, 32'd4);
        frame.ap_address = rand_address();
        frame.now_tick   = 32'd6100;
        send_frame(frame);
    endtask

    // A threshold of zero is always reached, so every frame alerts.
    task automatic test_zero_threshold();
        dfd_pkg::in_word_t frame;
        write_register(dfd_pkg::CFG_COUNT_THRESHOLD, 32'd0);
        for (int i = 0; i < 2; i++) begin
            frame.ap_address = rand_address();
            frame.now_tick   = 32'd7000 + i;
            send_frame(frame);
        end
    endtask

    // A zero window counts nothing, not even the frame just written. The
    // write to the unused index must leave all registers as they are.
    task automatic test_zero_window();
        dfd_pkg::in_word_t frame;
        write_register(dfd_pkg::CFG_WINDOW_TICKS, 32'd0);
        write_register(dfd_pkg::CFG_COUNT_THRESHOLD, 32'd1);
        write_register(CFG_SPARE_INDEX, 32'hFFFF_FFFF);
        for (int i = 0; i < 2; i++) begin
            frame.ap_address = rand_address();
            frame.now_tick   = 32'd8000;
            send_frame(frame);
        end
    endtask

    // Ticks that wrap past 2^32, with the widest window and the highest
    // threshold, so that ages computed across the wrap are counted.
    task automatic test_tick_wrap();
        dfd_pkg::in_word_t frame;
        write_register(dfd_pkg::CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
        write_register(dfd_pkg::CFG_COUNT_THRESHOLD, 32'd255);
        frame.ap_address = rand_address();
        frame.now_tick   = 32'hFFFF_FFFF;
        send_frame(frame);
        frame.ap_address = rand_address();
        frame.now_tick   = 32'h0000_0000;
        send_frame(frame);
        frame.ap_address = rand_address();
        frame.now_tick   = 32'h8000_0000;
        send_frame(frame);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic in phases, each with its own register settings. Most
    // frames advance the tick by small steps, so the count builds up and
    // floods get detected. The rest are large jumps, steps backward (stamps
    // from the future) and random ticks.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        dfd_pkg::in_word_t          frame;
        logic [dfd_pkg::TICK_W-1:0] tick;
        int unsigned                step_max;
        int unsigned                pick;
        tick = $urandom;
        for (int p = 0; p < 12; p++) begin
            write_register(dfd_pkg::CFG_DETECT_ENABLE,
                           ($urandom_range(0, 9) == 0) ? 32'd0 : 32'd1);
            case ($urandom_range(0, 6))
                0:       write_register(dfd_pkg::CFG_WINDOW_TICKS, 32'd0);
                1:       write_register(dfd_pkg::CFG_WINDOW_TICKS, 32'd1);
                2:       write_register(dfd_pkg::CFG_WINDOW_TICKS, $urandom_range(2, 200));
                3:       write_register(dfd_pkg::CFG_WINDOW_TICKS,
                                        $urandom_range(200, 20000));
                4:       write_register(dfd_pkg::CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
                5:       write_register(dfd_pkg::CFG_WINDOW_TICKS, $urandom);
                default: write_register(dfd_pkg::CFG_WINDOW_TICKS, dfd_pkg::WINDOW_TICKS_RST);
            endcase
            case ($urandom_range(0, 5))
                0:       write_register(dfd_pkg::CFG_COUNT_THRESHOLD, 32'd0);
                1:       write_register(dfd_pkg::CFG_COUNT_THRESHOLD, 32'd1);
                2:       write_register(dfd_pkg::CFG_COUNT_THRESHOLD, $urandom_range(2, 12));
                3:       write_register(dfd_pkg::CFG_COUNT_THRESHOLD, $urandom_range(13, 32));
                4:       write_register(dfd_pkg::CFG_COUNT_THRESHOLD,
                                        ($urandom_range(0, 1) == 0) ? 32'd33 : 32'd255);
                default: write_register(dfd_pkg::CFG_COUNT_THRESHOLD, $urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_register(CFG_SPARE_INDEX, $urandom);
            end
            case ($urandom_range(0, 3))
                0:       step_max = 2;
                1:       step_max = 40;
                2:       step_max = 600;
                default: step_max = 3000;
            endcase
            // Start some phases just below the wrap point of the tick.
            if ($urandom_range(0, 3) == 0) begin
                tick = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            end
            for (int k = 0; k < 80; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    tick = tick + $urandom_range(0, step_max);
                end else if (pick < 87) begin
                    tick = tick + $urandom_range(step_max, 32'h00FF_FFFF);
                end else if (pick < 95) begin
                    tick = tick - $urandom_range(1, step_max + 1);
                end else begin
                    tick = $urandom;
                end
                frame.ap_address = rand_address();
                frame.now_tick   = tick;
                send_frame(frame);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset once, then the tests in turn. At the end, wait for
    // every result, then allow a full walk of the ring so that any stray
    // extra word would still be seen by the checker.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_default_threshold();
        test_detect_disabled();
        test_zero_threshold();
        test_zero_window();
        test_tick_wrap();
        test_random_traffic();

        drain_results();
        repeat (RECORD_DEPTH + 8) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== deauth_flood_detector_top.f =====
rtl/core/dfd_pkg.sv
rtl/core/dfd_cell.sv
rtl/core/deauth_flood_detector_top.sv
tb/sv/tb_deauth_flood_detector_top.sv
